// File: sv/lscp_pkg.sv
// Shared types, constants and helper functions of the LED strip chase pattern block.
package lscp_pkg;

	// Field widths of the input and result words.
	localparam int SID_W  = 6;
	localparam int IDX_W  = 8;
	localparam int MODE_W = 4;
	localparam int CNT_W  = 8;
	localparam int COL_W  = 8;
	localparam int LVL_W  = 16;
	localparam int CN_W   = 8;
	localparam int PHASE_W = 2;

	// Default number of strips that keep a chase phase.
	localparam int NUM_STRIPS_DEF = 64;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Level bar scaling: half the bar is level * count / 200, done as a reciprocal multiply.
	localparam int LEVEL_SCALE = 100;
	localparam int PROD_W      = LVL_W + CNT_W;
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 31;
	localparam logic [RECIP_W-1:0] RECIP_SCALE =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(LEVEL_SCALE) - 64'd1) / 64'(LEVEL_SCALE));
	localparam int WIDE_W = PROD_W + RECIP_W;
	localparam int HALF_W = WIDE_W - (RECIP_SHIFT + 1);

	// Mode codes.
	localparam logic [MODE_W-1:0] MODE_STATIC    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_FWD       = 4'd1;
	localparam logic [MODE_W-1:0] MODE_BACK      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_TO_CTR    = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FROM_CTR  = 4'd4;
	localparam logic [MODE_W-1:0] MODE_GAS       = 4'd5;
	localparam logic [MODE_W-1:0] MODE_PULSE     = 4'd6;
	localparam logic [MODE_W-1:0] MODE_LEVEL     = 4'd7;

	// Control numbers whose alarm colour is red; every other number gets green.
	localparam logic [CN_W-1:0] CN_RED_A = 8'd108;
	localparam logic [CN_W-1:0] CN_RED_B = 8'd109;
	localparam logic [CN_W-1:0] CN_RED_C = 8'd112;
	localparam logic [CN_W-1:0] CN_RED_D = 8'd113;
	localparam logic [CN_W-1:0] CN_RED_E = 8'd114;
	localparam logic [CN_W-1:0] CN_RED_F = 8'd115;
	localparam logic [CN_W-1:0] CN_RED_G = 8'd124;
	localparam logic [CN_W-1:0] CN_RED_H = 8'd125;

	// Pixels of the level bar drawn in yellow.
	localparam logic [IDX_W-1:0] YELLOW_FIRST = 8'd8;
	localparam logic [IDX_W-1:0] YELLOW_LAST  = 8'd11;

	localparam logic [COL_W-1:0] COL_FULL = 8'd255;
	localparam logic [COL_W-1:0] COL_NONE = 8'd0;

	// One input word: one pixel of one strip.
	typedef struct packed {
		logic [SID_W-1:0]  strip_id;
		logic [IDX_W-1:0]  pixel_index;
		logic              end_of_strip;
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0]  pixel_count;
		logic [COL_W-1:0]  base_red;
		logic [COL_W-1:0]  base_green;
		logic [COL_W-1:0]  base_blue;
		logic              switch_on;
		logic [LVL_W-1:0]  level_value;
		logic              force_alarm;
		logic [CN_W-1:0]   control_number;
	} in_word_t;

	// One result word: the colour of one pixel.
	typedef struct packed {
		logic [COL_W-1:0] out_red;
		logic [COL_W-1:0] out_green;
		logic [COL_W-1:0] out_blue;
		logic [IDX_W-1:0] out_index;
		logic             out_last;
	} out_word_t;

	// A classified pixel as it waits in the queue for the phase lookup.
	typedef struct packed {
		logic [SID_W-1:0]   sid;
		logic               upd;
		logic               dir_back;
		logic               fixed;
		logic               lit_fixed;
		logic [PHASE_W-1:0] target;
		logic [COL_W-1:0]   red;
		logic [COL_W-1:0]   green;
		logic [COL_W-1:0]   blue;
		logic [IDX_W-1:0]   idx;
		logic               last;
	} entry_t;

	// True when the control number selects the red alarm colour.
	function automatic logic alarm_is_red(input logic [CN_W-1:0] cn);
		return (cn == CN_RED_A) || (cn == CN_RED_B) || (cn == CN_RED_C) || (cn == CN_RED_D) ||
			(cn == CN_RED_E) || (cn == CN_RED_F) || (cn == CN_RED_G) || (cn == CN_RED_H);
	endfunction

	// Index modulo 3: base-4 digits sum to the same residue since 4 is 1 mod 3.
	function automatic logic [PHASE_W-1:0] mod3(input logic [IDX_W-1:0] v);
		logic [3:0] s_a;
		logic [2:0] s_b;
		logic [PHASE_W-1:0] r;
		s_a = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		s_b = 3'(s_a[1:0]) + 3'(s_a[3:2]);
		case (s_b)
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4:       r = 2'd1;
			3'd2, 3'd5:       r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/lscp_in_if.sv
// Input channel: one pixel word with a valid/ready handshake.
interface lscp_in_if;
	import lscp_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/lscp_out_if.sv
// Output channel: one pixel colour word with a valid/ready handshake.
interface lscp_out_if;
	import lscp_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/led_strip_chase_pattern_top.sv
// A word passes through front stages 1 and 2, the queue, the lookup stage and the output register.
// Throughput: one word per cycle while the output takes results; back-pressure holds the back, queue and front.
// Gas words and pulse words with the switch on leave no result and take no queue slot.
// Reset clears all control state; every strip's chase phase reads as zero after reset
// through per-strip written flags, so no clearing pass is needed.
module led_strip_chase_pattern_top #(
	parameter int NUM_STRIPS = lscp_pkg::NUM_STRIPS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lscp_in_if.sink    pix_in,
	lscp_out_if.source pix_out
);
	import lscp_pkg::*;

	logic   push, full, pop, not_empty;
	entry_t push_ent, head_ent;

	// Front: accept and classify.
	lscp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_in),
		.push     (push),
		.push_ent (push_ent),
		.full     (full)
	);

	// Queue between the two parts.
	lscp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.full      (full),
		.pop       (pop),
		.head_ent  (head_ent),
		.not_empty (not_empty)
	);

	// Back: phase lookup, phase update and result word.
	lscp_back #(
		.NUM_STRIPS (NUM_STRIPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_ent  (head_ent),
		.not_empty (not_empty),
		.pop       (pop),
		.pix_out   (pix_out)
	);

endmodule

// File: sv/lscp_front.sv
// Front part: accepts pixel words, scales the level bar and classifies each word.
module lscp_front (
	input  logic             clk,
	input  logic             arst_n,
	lscp_in_if.sink          pix_in,
	output logic             push,
	output lscp_pkg::entry_t push_ent,
	input  logic             full
);
	import lscp_pkg::*;

	logic              v_s1_q, v_s2_q;
	in_word_t          w_s1, w_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [HALF_W-1:0] half_s2;
	logic [WIDE_W-1:0] wide;
	logic              adv;
	logic              emit;

	// The whole front moves when its last stage can leave.
	assign adv = !v_s2_q || !emit || !full;
	assign pix_in.ready = adv;
	assign push = v_s2_q && emit && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else if (adv) begin
			v_s1_q <= pix_in.valid;
			v_s2_q <= v_s1_q;
		end
	end

	// Stage 1 forms level * count; stage 2 divides it by two hundred.
	assign wide = WIDE_W'(prod_s1) * WIDE_W'(RECIP_SCALE);

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1    <= pix_in.data;
			prod_s1 <= PROD_W'(pix_in.data.level_value) * PROD_W'(pix_in.data.pixel_count);
			w_s2    <= w_s1;
			half_s2 <= wide[WIDE_W-1 -: HALF_W];
		end
	end

	// Classification of the word in stage 2.
	logic [COL_W-1:0]   lit_r, lit_g, lit_b;
	logic [PHASE_W-1:0] idx_r, tgt_fwd;
	logic               lower_half, on_bar, yellow;
	logic [CNT_W-1:0]   half_cnt;
	logic [IDX_W-1:0]   tail_len;
	entry_t             ent;

	always_comb begin
		// Lit colour: base colour, or the alarm colour when forced.
		if (w_s2.force_alarm) begin
			lit_r = alarm_is_red(w_s2.control_number) ? COL_FULL : COL_NONE;
			lit_g = alarm_is_red(w_s2.control_number) ? COL_NONE : COL_FULL;
			lit_b = COL_NONE;
		end else begin
			lit_r = w_s2.base_red;
			lit_g = w_s2.base_green;
			lit_b = w_s2.base_blue;
		end

		idx_r      = mod3(w_s2.pixel_index);
		tgt_fwd    = (idx_r == 2'd0) ? 2'd0 : (2'd3 - idx_r);
		half_cnt   = w_s2.pixel_count >> 1;
		lower_half = w_s2.pixel_index < half_cnt;

		// Level bar grows from both ends; past the end the distance is negative and lit.
		tail_len = w_s2.pixel_count - w_s2.pixel_index;
		if (lower_half)
			on_bar = HALF_W'(w_s2.pixel_index) < half_s2;
		else if (w_s2.pixel_count < w_s2.pixel_index)
			on_bar = 1'b1;
		else
			on_bar = HALF_W'(tail_len) < half_s2;
		yellow = (w_s2.pixel_index >= YELLOW_FIRST) && (w_s2.pixel_index <= YELLOW_LAST);

		ent.sid       = w_s2.strip_id;
		ent.upd       = 1'b0;
		ent.dir_back  = 1'b0;
		ent.fixed     = 1'b1;
		ent.lit_fixed = 1'b1;
		ent.target    = tgt_fwd;
		ent.red       = lit_r;
		ent.green     = lit_g;
		ent.blue      = lit_b;
		ent.idx       = w_s2.pixel_index;
		ent.last      = w_s2.end_of_strip;
		emit          = 1'b1;

		case (w_s2.mode)
			MODE_GAS: begin
				emit = 1'b0;
			end
			MODE_LEVEL: begin
				ent.lit_fixed = on_bar;
				ent.red       = yellow ? COL_FULL : w_s2.base_red;
				ent.green     = yellow ? COL_FULL : w_s2.base_green;
				ent.blue      = yellow ? COL_NONE : w_s2.base_blue;
			end
			MODE_PULSE: begin
				emit          = !w_s2.switch_on;
				ent.lit_fixed = w_s2.force_alarm;
			end
			MODE_FWD, MODE_BACK: begin
				if (w_s2.switch_on) begin
					ent.fixed    = 1'b0;
					ent.upd      = w_s2.end_of_strip;
					ent.dir_back = (w_s2.mode == MODE_BACK);
				end else begin
					ent.lit_fixed = w_s2.force_alarm;
				end
			end
			MODE_TO_CTR, MODE_FROM_CTR: begin
				if (w_s2.switch_on) begin
					ent.fixed    = 1'b0;
					ent.upd      = w_s2.end_of_strip;
					ent.dir_back = (w_s2.mode == MODE_FROM_CTR);
					ent.target   = lower_half ? tgt_fwd : idx_r;
				end else begin
					ent.lit_fixed = w_s2.force_alarm;
				end
			end
			default: begin
				// Static and the remaining modes light every pixel while on or while an alarm is forced.
				ent.lit_fixed = w_s2.switch_on || w_s2.force_alarm;
			end
		endcase
	end

	assign push_ent = ent;

endmodule

// File: sv/lscp_queue.sv
// Short queue of classified pixels between the front and the back.
module lscp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lscp_pkg::entry_t push_ent,
	output logic             full,
	input  logic             pop,
	output lscp_pkg::entry_t head_ent,
	output logic             not_empty
);
	import lscp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

	entry_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W_Q-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W_Q'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_ent  = ent_q[rd_ptr_q];

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_ent;
	end

endmodule

// File: sv/lscp_back.sv
// Back part: looks up and updates the per-strip chase phase and drives the result word.
module lscp_back #(
	parameter int NUM_STRIPS = lscp_pkg::NUM_STRIPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lscp_pkg::entry_t head_ent,
	input  logic             not_empty,
	output logic             pop,
	lscp_out_if.source       pix_out
);
	import lscp_pkg::*;

	localparam int ID_SPACE = 2 ** SID_W;
	localparam int DEPTH    = (NUM_STRIPS < ID_SPACE) ? NUM_STRIPS : ID_SPACE;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PHASE_W-1:0] phase_mem [DEPTH];
	logic [DEPTH-1:0]   written_q;

	entry_t             ent_s3;
	logic               v_s3_q;
	logic [PHASE_W-1:0] rd_s3;
	logic               rv_s3;
	logic               vid_s3;

	logic [SID_W-1:0]   byp_sid_q;
	logic [PHASE_W-1:0] byp_val_q;
	logic               byp_v_q;

	out_word_t          out_q;
	logic               out_v_q;

	logic               go;
	logic               wr;
	logic               lit;
	logic [PHASE_W-1:0] phase, phase_nxt;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic               head_vid;

	// Handshake: the output register frees the lookup stage, which frees the queue.
	assign go  = !out_v_q || pix_out.ready;
	assign pop = not_empty && (!v_s3_q || go);

	assign rd_addr  = head_ent.sid[AW-1:0];
	assign wr_addr  = ent_s3.sid[AW-1:0];
	assign head_vid = 32'(head_ent.sid) < NUM_STRIPS;

	// Phase of the strip: the latest write wins over the registered read.
	always_comb begin
		if (!vid_s3)
			phase = '0;
		else if (byp_v_q && (byp_sid_q == ent_s3.sid))
			phase = byp_val_q;
		else if (rv_s3)
			phase = rd_s3;
		else
			phase = '0;
		lit = ent_s3.fixed ? ent_s3.lit_fixed : (phase == ent_s3.target);
		if (ent_s3.dir_back)
			phase_nxt = (phase == 2'd0) ? 2'd2 : phase - 2'd1;
		else
			phase_nxt = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
	end

	assign wr = v_s3_q && go && ent_s3.upd && vid_s3;

	// Phase memory: one read and one write port.
	always_ff @(posedge clk) begin
		if (wr)
			phase_mem[wr_addr] <= phase_nxt;
		if (pop)
			rd_s3 <= phase_mem[rd_addr];
	end

	// Control state: written flags, lookup stage valid, bypass and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			v_s3_q    <= 1'b0;
			byp_v_q   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (wr) begin
				written_q[wr_addr] <= 1'b1;
				byp_v_q            <= 1'b1;
			end
			if (pop)
				v_s3_q <= 1'b1;
			else if (go)
				v_s3_q <= 1'b0;
			if (go)
				out_v_q <= v_s3_q;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s3 <= head_ent;
			vid_s3 <= head_vid;
			rv_s3  <= head_vid && written_q[rd_addr];
		end
		if (wr) begin
			byp_sid_q <= ent_s3.sid;
			byp_val_q <= phase_nxt;
		end
		if (go && v_s3_q) begin
			out_q.out_red   <= lit ? ent_s3.red : COL_NONE;
			out_q.out_green <= lit ? ent_s3.green : COL_NONE;
			out_q.out_blue  <= lit ? ent_s3.blue : COL_NONE;
			out_q.out_index <= ent_s3.idx;
			out_q.out_last  <= ent_s3.last;
		end
	end

	assign pix_out.valid = out_v_q;
	assign pix_out.data  = out_q;

endmodule
